/* design/psdte_pkg.sv */
// ----------------------------------------------------------------------------
// psdte_pkg
// Types and constants shared by the thumbnail extractor files.
// ----------------------------------------------------------------------------
package psdte_pkg;

   localparam int unsigned MAX_W = 21;

   localparam logic [31:0]      SIG_FILE  = 32'h3842_5053;  // "8BPS"
   localparam logic [31:0]      SIG_RES   = 32'h3842_494D;  // "8BIM"
   localparam logic [15:0]      ID_THUMB_A = 16'h0409;
   localparam logic [15:0]      ID_THUMB_B = 16'h040C;
   localparam logic [MAX_W-1:0] MAX_RESET  = 21'd1000000;

   typedef enum logic [3:0] {
      PH_HDR     = 4'd0,
      PH_LEN1    = 4'd1,
      PH_SKIP1   = 4'd2,
      PH_LEN2    = 4'd3,
      PH_RSIG    = 4'd4,
      PH_NAME    = 4'd5,
      PH_PAD     = 4'd6,
      PH_RLEN    = 4'd7,
      PH_RSKIP   = 4'd8,
      PH_THDR    = 4'd9,
      PH_PAYLOAD = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUNNING   = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_TRUNCATED = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       payload_valid;
      logic [2:0] status;
      logic       last;
   } rsp_payload_type;

   typedef logic [MAX_W-1:0] csr_payload_type;

   // handshake between input register and parser
   typedef struct packed {
      logic            valid;
      req_payload_type item;
   } stage_type;

endpackage

/* design/psdte_chan_if.sv */
// ----------------------------------------------------------------------------
// psdte_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface psdte_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* design/psd_thumbnail_extractor_unit.sv */
// ----------------------------------------------------------------------------
// psd_thumbnail_extractor_unit
// Walks a layered-image container byte by byte and streams out the embedded
// thumbnail payload, closing with a status on the last result.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                    role
//  req      in         in_byte, end_of_stream                     file bytes
//  rsp      out        out_byte, payload_valid, status, last      results
//  csr      in         max_thumbnail_bytes (21 bits)              size limit
//
//  one byte transaction per cycle sustained while rsp does not stall; a req byte
//  goes through the input register, then parser and result register, to rsp
//  synchronous active-high reset clears the parser and loads the limit 1000000
//  an rsp stall holds the result register; req keeps flowing while the
//  input register is empty or the result register is empty or drains in the
//  same cycle
//  csr writes are always taken
// ----------------------------------------------------------------------------
module psd_thumbnail_extractor_unit
   import psdte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   psdte_chan_if.sink   req,
   psdte_chan_if.sink   csr,
   psdte_chan_if.source rsp
);

   stage_type stage;
   logic      take;

   psdte_input_stage u_input_stage (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .take  (take),
      .stage (stage)
   );

   psdte_parser u_parser (
      .clock (clock),
      .reset (reset),
      .stage (stage),
      .take  (take),
      .csr   (csr),
      .rsp   (rsp)
   );

endmodule

/* design/psdte_input_stage.sv */
// ----------------------------------------------------------------------------
// psdte_input_stage
// Input register: holds one byte transaction until the parser takes it.
// ----------------------------------------------------------------------------
module psdte_input_stage
   import psdte_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   psdte_chan_if.sink req,
   input  logic      take,
   output stage_type stage
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type item_ff;
   logic            accept;

   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req.data;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

/* design/psdte_parser.sv */
// ----------------------------------------------------------------------------
// psdte_parser
// Container walk state machine, size limit register and result register.
// ----------------------------------------------------------------------------
module psdte_parser
   import psdte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  stage_type   stage,
   output logic        take,
   psdte_chan_if.sink  csr,
   psdte_chan_if.source rsp
);

   phase_type       phase_ff, phase_in;
   logic [31:0]     count_ff, count_in;
   logic [31:0]     length_ff, length_in;
   logic [31:0]     sig_ff, sig_in;
   logic [15:0]     res_id_ff, res_id_in;
   logic            name_odd_ff, name_odd_in;
   logic [MAX_W-1:0] remaining_ff, remaining_in;
   logic            finished_ff, finished_in;
   logic [MAX_W-1:0] max_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            step;
   logic            hit;
   logic            bad;
   logic [7:0]      b;
   logic            eos;

   assign take      = !rsp_valid_ff || rsp.ready;
   assign step      = stage.valid && take;
   assign b         = stage.item.in_byte;
   assign eos       = stage.item.end_of_stream;
   assign csr.ready = 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      length_in    = length_ff;
      sig_in       = sig_ff;
      res_id_in    = res_id_ff;
      name_odd_in  = name_odd_ff;
      remaining_in = remaining_ff;
      finished_in  = finished_ff;
      hit          = 1'b0;
      bad          = 1'b0;
      rsp_data_in  = '0;

      if (step && finished_ff) begin
         if (eos) begin
            finished_in = 1'b0;
         end
      end else if (step) begin
         unique case (phase_ff)
            PH_HDR, PH_RSIG: begin
               if (count_ff[31:2] == 30'd0) begin
                  sig_in = {sig_ff[23:0], b};
                  if (count_ff[1:0] == 2'd3 &&
                      sig_in != ((phase_ff == PH_HDR) ? SIG_FILE : SIG_RES)) begin
                     bad = 1'b1;
                  end
               end else if (phase_ff == PH_RSIG) begin
                  res_id_in = {res_id_ff[7:0], b};
               end
               if (bad) begin
                  finished_in        = 1'b1;
                  hit                = 1'b1;
                  rsp_data_in.status = ST_NOT_FOUND;
                  rsp_data_in.last   = 1'b1;
               end else begin
                  count_in = count_ff + 32'd1;
                  if (phase_ff == PH_HDR && count_in == 32'd26) begin
                     phase_in = PH_LEN1;
                     count_in = '0;
                  end else if (phase_ff == PH_RSIG && count_in == 32'd6) begin
                     phase_in    = PH_NAME;
                     name_odd_in = 1'b0;
                     count_in    = '0;
                  end
               end
            end
            PH_LEN1: begin
               length_in = {length_ff[23:0], b};
               count_in  = count_ff + 32'd1;
               if (count_in == 32'd4) begin
                  count_in = length_in;
                  phase_in = (length_in == 32'd0) ? PH_LEN2 : PH_SKIP1;
               end
            end
            PH_SKIP1, PH_RSKIP: begin
               count_in = count_ff - 32'd1;
               if (count_in == 32'd0) begin
                  phase_in = (phase_ff == PH_SKIP1) ? PH_LEN2 : PH_RSIG;
               end
            end
            PH_LEN2: begin
               count_in = count_ff + 32'd1;
               if (count_in == 32'd4) begin
                  phase_in = PH_RSIG;
                  count_in = '0;
               end
            end
            PH_NAME: begin
               if (b == 8'd0) begin
                  phase_in = name_odd_ff ? PH_RLEN : PH_PAD;
               end else begin
                  name_odd_in = !name_odd_ff;
               end
            end
            PH_PAD: begin
               phase_in = PH_RLEN;
            end
            PH_RLEN: begin
               length_in = {length_ff[23:0], b};
               count_in  = count_ff + 32'd1;
               if (count_in == 32'd4) begin
                  count_in = '0;
                  if (res_id_ff == ID_THUMB_A || res_id_ff == ID_THUMB_B) begin
                     phase_in = PH_THDR;
                  end else begin
                     // body length rounds up to even, all ones wraps to zero
                     count_in = length_in + {31'd0, length_in[0]};
                     phase_in = (count_in == 32'd0) ? PH_RSIG : PH_RSKIP;
                  end
               end
            end
            PH_THDR: begin
               if (count_ff < 32'd4) begin
                  sig_in = {sig_ff[23:0], b};
               end else if (count_ff >= 32'd20 && count_ff < 32'd24) begin
                  length_in = {length_ff[23:0], b};
               end
               count_in = count_ff + 32'd1;
               if (count_in == 32'd28) begin
                  count_in = '0;
                  priority if (sig_in != 32'd1) begin
                     finished_in        = 1'b1;
                     hit                = 1'b1;
                     rsp_data_in.status = ST_NOT_FOUND;
                     rsp_data_in.last   = 1'b1;
                  end else if (length_in >= {{(32-MAX_W){1'b0}}, max_ff}) begin
                     finished_in        = 1'b1;
                     hit                = 1'b1;
                     rsp_data_in.status = ST_TOO_LARGE;
                     rsp_data_in.last   = 1'b1;
                  end else if (length_in == 32'd0) begin
                     finished_in        = 1'b1;
                     hit                = 1'b1;
                     rsp_data_in.status = ST_COMPLETE;
                     rsp_data_in.last   = 1'b1;
                  end else begin
                     remaining_in = length_in[MAX_W-1:0];
                     phase_in     = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               hit                       = 1'b1;
               rsp_data_in.out_byte      = b;
               rsp_data_in.payload_valid = 1'b1;
               remaining_in              = remaining_ff - {{(MAX_W-1){1'b0}}, 1'b1};
               if (remaining_in == '0) begin
                  finished_in        = 1'b1;
                  rsp_data_in.status = ST_COMPLETE;
                  rsp_data_in.last   = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HDR;
               count_in = '0;
            end
         endcase

         // stream ended before a final result
         if (eos && !finished_in) begin
            hit         = 1'b1;
            rsp_data_in = '0;
            rsp_data_in.last   = 1'b1;
            rsp_data_in.status = (phase_in == PH_THDR || phase_in == PH_PAYLOAD) ?
                                 ST_TRUNCATED : ST_NOT_FOUND;
         end
         if (eos) begin
            finished_in = 1'b0;
         end
      end

      // rearm for the next file
      if (step && eos) begin
         phase_in     = PH_HDR;
         count_in     = '0;
         length_in    = '0;
         sig_in       = '0;
         res_id_in    = '0;
         name_odd_in  = 1'b0;
         remaining_in = '0;
      end
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = step && hit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         count_ff     <= '0;
         length_ff    <= '0;
         sig_ff       <= '0;
         res_id_ff    <= '0;
         name_odd_ff  <= 1'b0;
         remaining_ff <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         sig_ff       <= sig_in;
         res_id_ff    <= res_id_in;
         name_odd_ff  <= name_odd_in;
         remaining_ff <= remaining_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_RESET;
      end else if (csr.valid) begin
         max_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (step && hit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule
